/* rtl/interval_reservation_table_macros.svh */
// Assertion macros used by the checker file.
// No dependencies; expects clk_i and rst_ni in the including scope.
`ifndef INTERVAL_RESERVATION_TABLE_MACROS_SVH
`define INTERVAL_RESERVATION_TABLE_MACROS_SVH

// same-cycle implication
`define IRT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define IRT_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/irt_pkg.sv */
// Types and codes for the interval reservation table.
// No dependencies.
package irt_pkg;

  typedef enum logic [1:0] {
    ST_ACCEPTED = 2'd0,
    ST_OVERLAP  = 2'd1,
    ST_FULL     = 2'd2,
    ST_INVALID  = 2'd3
  } irt_status_e;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned CountW = 7;

  // request traveling down the cell chain
  typedef struct packed {
    logic             vld;
    logic             bad;  // empty or reversed interval
    logic             hit;  // overlap seen so far
    logic [TimeW-1:0] start_time;
    logic [TimeW-1:0] end_time;
  } irt_token_t;

endpackage

/* rtl/irt_cell.sv */
// One table entry: holds an interval and checks the passing request against it.
// Depends on irt_pkg.
module irt_cell #(
  parameter int unsigned CNT_W = 7,
  parameter int unsigned IDX   = 0
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  irt_pkg::irt_token_t            tok_i,
  output irt_pkg::irt_token_t            tok_o,
  input  logic [CNT_W-1:0]               count_i,
  input  logic                           wr_en_i,
  input  logic [irt_pkg::TimeW-1:0]      wr_start_i,
  input  logic [irt_pkg::TimeW-1:0]      wr_end_i
);

  logic [irt_pkg::TimeW-1:0] start_q, end_q;
  irt_pkg::irt_token_t       tok_d, tok_q;
  logic                      held, overlap;

  // only entries below the fill count are live
  assign held    = CNT_W'(IDX) < count_i;
  assign overlap = held && ($signed(start_q) < $signed(tok_i.end_time))
                        && ($signed(end_q) > $signed(tok_i.start_time));

  always_comb begin
    tok_d     = tok_i;
    tok_d.hit = tok_i.hit | (overlap & ~tok_i.bad);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i && (count_i == CNT_W'(IDX))) begin
      start_q <= wr_start_i;
      end_q   <= wr_end_i;
    end
  end

  assign tok_o = tok_q;

endmodule

/* rtl/interval_reservation_table.sv */
// An accepted start passes the register of every cell, then the done_o register, before the strobe.
// One request at a time: the request walks the cell chain one cell per cycle,
// and start is taken again in the cycle the result shows.
// Reset clears the fill count, busy and the chain; stored intervals are not cleared.
// done_o cannot be stalled by the receiver.
module interval_reservation_table #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  input  logic signed [31:0]            start_time_i,
  input  logic signed [31:0]            end_time_i,
  output logic                          busy,
  output logic                          done_o,
  output logic [1:0]                    status_o,
  output logic [6:0]                    stored_count_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  irt_pkg::irt_token_t tok [CAPACITY+1];
  irt_pkg::irt_token_t tail;
  irt_pkg::irt_status_e status;
  logic                accept, wr_en;
  logic [CntW-1:0]     count_q, count_d;
  logic                busy_q, done_q;
  irt_pkg::irt_status_e status_q;
  logic [6:0]          stored_q;

  assign accept = start && !busy_q;

  always_comb begin
    tok[0].vld        = accept;
    tok[0].bad        = !($signed(start_time_i) < $signed(end_time_i));
    tok[0].hit        = 1'b0;
    tok[0].start_time = start_time_i;
    tok[0].end_time   = end_time_i;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    irt_cell #(.CNT_W(CntW), .IDX(i)) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .tok_i      (tok[i]),
      .tok_o      (tok[i+1]),
      .count_i    (count_q),
      .wr_en_i    (wr_en),
      .wr_start_i (tail.start_time),
      .wr_end_i   (tail.end_time)
    );
  end

  assign tail = tok[CAPACITY];

  always_comb begin
    if (tail.bad) begin
      status = irt_pkg::ST_INVALID;
    end else if (tail.hit) begin
      status = irt_pkg::ST_OVERLAP;
    end else if (count_q >= CntW'(CAPACITY)) begin
      status = irt_pkg::ST_FULL;
    end else begin
      status = irt_pkg::ST_ACCEPTED;
    end
  end

  assign wr_en   = tail.vld && (status == irt_pkg::ST_ACCEPTED);
  assign count_d = wr_en ? count_q + CntW'(1) : count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= tail.vld;
      if (accept) begin
        busy_q <= 1'b1;
      end else if (tail.vld) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tail.vld) begin
      status_q <= status;
      stored_q <= 7'(count_d);
    end
  end

  assign busy           = busy_q;
  assign done_o         = done_q;
  assign status_o       = status_q;
  assign stored_count_o = stored_q;

endmodule

/* rtl/irt_checker.sv */
// Port-level checks for the interval reservation table, bound to the top level.
// Depends on interval_reservation_table_macros.svh and irt_pkg.
`include "interval_reservation_table_macros.svh"

module irt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        done_o,
  input logic [1:0]  status_o,
  input logic [6:0]  stored_count_o
);

  logic full_seen;
  assign full_seen = done_o && (status_o == irt_pkg::ST_FULL);

  `IRT_ASSERT_NXT(a_accept_busy, start && !busy, busy)
  `IRT_ASSERT_IMP(a_done_idle, done_o, !busy)
  `IRT_ASSERT_NXT(a_done_pulse, done_o, !done_o)
  `IRT_ASSERT_IMP(a_busy_cause, $rose(busy), $past(start))
  `IRT_ASSERT_NXT(a_full_sticky, full_seen && done_o, $stable(stored_count_o))

endmodule

bind interval_reservation_table irt_checker u_irt_checker (.*);
